/* design/c2pr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pr_pkg: shared constants, types and pitch tables
// fixed-point formats, divide-by-constant factors and the four ratio tables
// ----------------------------------------------------------------------------
package c2pr_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int TABLE_BITS = 24;

  localparam int IN_W    = 16;
  localparam int MAG_W   = IN_W + 1;
  localparam int OUT_W   = 31;
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

  // table entries stay below 2.0, so one integer bit
  localparam int TENT_W = TABLE_BITS + 1;
  localparam int PROD_W = 2 * TENT_W;

  localparam int CENTS_PER_OCT  = 1200;
  localparam int CENTS_PER_SEMI = 100;
  localparam int SEMIS          = 12;

  localparam int OCT_W  = 5;
  localparam int REM_W  = 11;
  localparam int SEMI_W = 4;
  localparam int CI_W   = 7;

  // mag / 1200 as (mag * OCT_MUL) >> OCT_SHIFT, exact for mag below 59074
  localparam int OCT_MUL   = 55925;
  localparam int OCT_SHIFT = 26;
  localparam int OCT_PROD_W = MAG_W + 16;
  // rem / 100 as (rem * SEMI_MUL) >> SEMI_SHIFT, exact for rem below 1200
  localparam int SEMI_MUL   = 5243;
  localparam int SEMI_SHIFT = 19;
  localparam int SEMI_PROD_W = REM_W + 13;

  // largest octave count (from a magnitude of 32768)
  localparam int OCT_MAX = ((1 << (IN_W - 1)) / CENTS_PER_OCT);
  // left headroom so the largest upward shift becomes a right shift of zero
  localparam int L_PAD   = OCT_MAX - (TABLE_BITS - FRAC_BITS);
  localparam int SH_BIAS = L_PAD + TABLE_BITS - FRAC_BITS;
  localparam int SH_W    = 6;
  localparam int WIDE_W  = TENT_W + L_PAD;

  // table generator
  localparam int          GEN_BITS = 48;
  localparam logic [63:0] GEN_STEP = 64'd162633287901;

  typedef logic [TENT_W-1:0] tent_t;

  typedef struct packed {
    tent_t [SEMIS-1:0]          semi;
    tent_t [CENTS_PER_SEMI-1:0] cent;
    tent_t [SEMIS-1:0]          isemi;
    tent_t [CENTS_PER_SEMI-1:0] icent;
  } tables_t;

  // product leaving the multiplier stage, with its right-shift amount
  typedef struct packed {
    logic [TENT_W-1:0] p;
    logic [SH_W-1:0]   sh;
  } prod_t;

  function automatic tent_t round_gen(input logic [63:0] v, input int s);
    logic [63:0] half;
    logic [63:0] sum;
    half = 64'd1 << (s - TABLE_BITS - 1);
    sum  = v + half;
    return tent_t'(sum >> (s - TABLE_BITS));
  endfunction

  // elaboration-time build of the geometric sequence 2^(k/1200)
  function automatic tables_t build_tables();
    tables_t      t;
    logic [63:0]  g;
    logic [127:0] gp;
    t = '0;
    g = 64'd1 << GEN_BITS;
    t.isemi[0] = tent_t'(1) << TABLE_BITS;
    t.icent[0] = tent_t'(1) << TABLE_BITS;
    for (int k = 0; k < CENTS_PER_OCT; k++) begin
      if (k > 0) begin
        gp = {64'd0, g} * {64'd0, GEN_STEP};
        g  = g + gp[GEN_BITS +: 64];
      end
      if (k % CENTS_PER_SEMI == 0)
        t.semi[k / CENTS_PER_SEMI] = round_gen(g, GEN_BITS);
      if (k < CENTS_PER_SEMI)
        t.cent[k] = round_gen(g, GEN_BITS);
      if (k >= CENTS_PER_SEMI && k % CENTS_PER_SEMI == 0)
        t.isemi[(CENTS_PER_OCT - k) / CENTS_PER_SEMI] = round_gen(g, GEN_BITS + 1);
      if (k > CENTS_PER_OCT - CENTS_PER_SEMI)
        t.icent[CENTS_PER_OCT - k] = round_gen(g, GEN_BITS + 1);
    end
    return t;
  endfunction

  localparam tables_t TABLES = build_tables();

endpackage

/* design/c2pr_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pr_pipe: octave split, table lookup and product pipeline
// seven stages with travelling valid bits; a stage moves when the next is free
// ----------------------------------------------------------------------------
module c2pr_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [c2pr_pkg::IN_W-1:0]     in_cents,
  output logic                          out_valid,
  input  logic                          out_ready,
  output c2pr_pkg::prod_t               out_prod
);

  localparam int NST = 7;

  logic [NST:1] v_r, v_nxt;
  logic [NST+1:1] en;

  // stage payloads
  logic                              neg1_r, neg2_r, neg3_r, neg4_r;
  logic [c2pr_pkg::MAG_W-1:0]        mag1_r, mag2_r;
  logic [c2pr_pkg::OCT_W-1:0]        oct2_r, oct3_r;
  logic [c2pr_pkg::REM_W-1:0]        rem3_r, rem4_r;
  logic [c2pr_pkg::SEMI_W-1:0]       si4_r;
  logic [c2pr_pkg::SH_W-1:0]         sh4_r, sh5_r, sh6_r, sh7_r;
  logic                              neg5_r;
  logic [c2pr_pkg::CI_W-1:0]         ci5_r;
  c2pr_pkg::tent_t                   fa5_r, fa6_r, fb6_r;
  logic [c2pr_pkg::TENT_W-1:0]       p7_r;

  logic [c2pr_pkg::MAG_W-1:0]        ext;
  logic [c2pr_pkg::MAG_W-1:0]        mag_nxt;
  logic [c2pr_pkg::OCT_PROD_W-1:0]   oct_prod;
  logic [c2pr_pkg::MAG_W-1:0]        rem_full;
  logic [c2pr_pkg::SEMI_PROD_W-1:0]  semi_prod;
  logic [c2pr_pkg::SH_W-1:0]         sh_nxt;
  logic [c2pr_pkg::REM_W-1:0]        ci_full;
  c2pr_pkg::tent_t                   fa_nxt, fb_nxt;
  logic [c2pr_pkg::PROD_W-1:0]       prod;

  // stall chain: a stage loads when empty or when its content moves on
  always_comb begin
    en[NST+1] = out_ready;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  always_comb begin
    v_nxt = v_r;
    if (en[1]) v_nxt[1] = in_valid;
    for (int k = 2; k <= NST; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: magnitude, most negative input keeps 32768
  assign ext     = {in_cents[c2pr_pkg::IN_W-1], in_cents};
  assign mag_nxt = in_cents[c2pr_pkg::IN_W-1] ? (~ext + c2pr_pkg::MAG_W'(1)) : ext;

  // stage 2: octave count by reciprocal multiply
  assign oct_prod = c2pr_pkg::OCT_PROD_W'(mag1_r) *
                    c2pr_pkg::OCT_PROD_W'(c2pr_pkg::OCT_MUL);

  // stage 3: remainder within the octave
  assign rem_full = mag2_r - c2pr_pkg::MAG_W'(oct2_r) *
                    c2pr_pkg::MAG_W'(c2pr_pkg::CENTS_PER_OCT);

  // stage 4: semitone index and shift amount
  assign semi_prod = c2pr_pkg::SEMI_PROD_W'(rem3_r) *
                     c2pr_pkg::SEMI_PROD_W'(c2pr_pkg::SEMI_MUL);
  assign sh_nxt = neg3_r ?
                  c2pr_pkg::SH_W'(c2pr_pkg::SH_BIAS) + c2pr_pkg::SH_W'(oct3_r) :
                  c2pr_pkg::SH_W'(c2pr_pkg::SH_BIAS) - c2pr_pkg::SH_W'(oct3_r);

  // stage 5: cent index and semitone factor
  assign ci_full = rem4_r - c2pr_pkg::REM_W'(si4_r) *
                   c2pr_pkg::REM_W'(c2pr_pkg::CENTS_PER_SEMI);
  assign fa_nxt  = neg4_r ? c2pr_pkg::TABLES.isemi[si4_r] : c2pr_pkg::TABLES.semi[si4_r];

  // stage 6: cent factor
  assign fb_nxt = neg5_r ? c2pr_pkg::TABLES.icent[ci5_r] : c2pr_pkg::TABLES.cent[ci5_r];

  // stage 7: product, truncated back to table precision
  assign prod = c2pr_pkg::PROD_W'(fa6_r) * c2pr_pkg::PROD_W'(fb6_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg1_r <= in_cents[c2pr_pkg::IN_W-1];
      mag1_r <= mag_nxt;
    end
    if (en[2]) begin
      neg2_r <= neg1_r;
      mag2_r <= mag1_r;
      oct2_r <= oct_prod[c2pr_pkg::OCT_SHIFT +: c2pr_pkg::OCT_W];
    end
    if (en[3]) begin
      neg3_r <= neg2_r;
      oct3_r <= oct2_r;
      rem3_r <= rem_full[c2pr_pkg::REM_W-1:0];
    end
    if (en[4]) begin
      neg4_r <= neg3_r;
      rem4_r <= rem3_r;
      si4_r  <= semi_prod[c2pr_pkg::SEMI_SHIFT +: c2pr_pkg::SEMI_W];
      sh4_r  <= sh_nxt;
    end
    if (en[5]) begin
      neg5_r <= neg4_r;
      ci5_r  <= ci_full[c2pr_pkg::CI_W-1:0];
      fa5_r  <= fa_nxt;
      sh5_r  <= sh4_r;
    end
    if (en[6]) begin
      fa6_r <= fa5_r;
      fb6_r <= fb_nxt;
      sh6_r <= sh5_r;
    end
    if (en[7]) begin
      p7_r  <= prod[c2pr_pkg::TABLE_BITS +: c2pr_pkg::TENT_W];
      sh7_r <= sh6_r;
    end
  end

  assign out_valid   = v_r[NST];
  assign out_prod.p  = p7_r;
  assign out_prod.sh = sh7_r;

  a_oct_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> oct2_r <= c2pr_pkg::OCT_MAX)
    else $error("octave count out of range");

endmodule

/* design/cents_to_pitch_ratio.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cents_to_pitch_ratio: cents offset to Q12 pitch ratio 2^(cents/1200)
// pipelined octave/semitone/cent split, table product and octave shift
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                       | tuser
//  in_      | in  | [15:0] cents (signed)       | -
//  out_     | out | [30:0] ratio_q12, [31] zero | [0] saturated
//
//  one transaction per cycle sustained while out_tready is high; results pass through the
//  seven-stage split/lookup/multiply pipeline and the shift/saturate output stage
//  rst_n (synchronous) empties every stage; payload is not cleared
//  an output stall fills empty stages first, so input keeps flowing into bubbles
// ----------------------------------------------------------------------------
module cents_to_pitch_ratio (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [c2pr_pkg::IN_W-1:0]       in_tdata,   // [15:0] cents
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [c2pr_pkg::TDATA_W-1:0]    out_tdata,  // [30:0] ratio_q12, [31] zero
  output logic                            out_tuser   // [0] saturated
);

  logic                          pipe_valid;
  logic                          pipe_ready;
  c2pr_pkg::prod_t               pipe_prod;

  logic                          out_valid_r, out_valid_nxt;
  logic [c2pr_pkg::OUT_W-1:0]    ratio_r, ratio_nxt;
  logic                          sat_r, sat_nxt;
  logic [c2pr_pkg::WIDE_W-1:0]   wide;
  logic [c2pr_pkg::WIDE_W-1:0]   shifted;

  c2pr_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cents  (in_tdata),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_prod  (pipe_prod)
  );

  assign pipe_ready = !out_valid_r || out_tready;

  // product scaled up by the headroom, then one right shift covers every octave
  assign wide    = {pipe_prod.p, {c2pr_pkg::L_PAD{1'b0}}};
  assign shifted = wide >> pipe_prod.sh;

  always_comb begin
    sat_nxt   = |shifted[c2pr_pkg::WIDE_W-1:c2pr_pkg::OUT_W];
    ratio_nxt = sat_nxt ? {c2pr_pkg::OUT_W{1'b1}} : shifted[c2pr_pkg::OUT_W-1:0];
    out_valid_nxt = out_valid_r;
    if (pipe_ready) out_valid_nxt = pipe_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ready && pipe_valid) begin
      ratio_r <= ratio_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(c2pr_pkg::TDATA_W - c2pr_pkg::OUT_W){1'b0}}, ratio_r};
  assign out_tuser  = sat_r;

  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |-> ratio_r == {c2pr_pkg::OUT_W{1'b1}})
    else $error("saturated result not clamped");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output register empty");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(ratio_r) && $stable(sat_r))
    else $error("result changed under stall");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for cents_to_pitch_ratio
// streams signed cent offsets in, predicts each Q12 pitch ratio and saturation
// flag with an independent table build, and checks every output transaction
// in order under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC = c2pr_pkg::FRAC_BITS;
  localparam int TBITS = c2pr_pkg::TABLE_BITS;
  localparam logic [63:0] STEP_D = 64'd162633287901;
  localparam logic [63:0] RATIO_MAX = 64'h7FFF_FFFF;
  localparam int LIMIT = 200000;
  localparam int QUIET_TAIL = 60;

  typedef struct packed {
    logic [30:0] ratio;
    logic        sat;
  } ratio_res_t;

  typedef struct packed {
    logic [15:0] cents;
    logic        drain;
  } cents_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [c2pr_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [c2pr_pkg::TDATA_W-1:0] out_tdata;
  logic out_tuser;

  cents_to_pitch_ratio dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ratio tables, 24 fraction bits
  logic [63:0] up_semi [12];
  logic [63:0] up_cent [100];
  logic [63:0] dn_semi [12];
  logic [63:0] dn_cent [100];

  cents_item_t cents_pend[$];
  ratio_res_t  ratio_due[$];

  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned cyc = 0;
  int errors = 0;
  int n_sat = 0;
  int n_zero = 0;
  int n_neg = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  int tx_pct = 10;
  int rx_pct = 10;
  logic quiet = 1'b0;

  function automatic logic [63:0] to_q24(logic [63:0] v, int s);
    return (v + (64'd1 << (s - TBITS - 1))) >> (s - TBITS);
  endfunction

  // geometric sequence 2^(k/1200) with 48 fraction bits
  task automatic make_ratio_tables();
    logic [63:0]  g;
    logic [127:0] prod;
    g = 64'd1 << 48;
    dn_semi[0] = 64'd1 << TBITS;
    dn_cent[0] = 64'd1 << TBITS;
    for (int k = 0; k < 1200; k++) begin
      if (k > 0) begin
        prod = {64'd0, g} * {64'd0, STEP_D};
        g = g + prod[48 +: 64];
      end
      if (k % 100 == 0) up_semi[k / 100] = to_q24(g, 48);
      if (k < 100) up_cent[k] = to_q24(g, 48);
      if (k >= 100 && k % 100 == 0) dn_semi[(1200 - k) / 100] = to_q24(g, 49);
      if (k > 1100) dn_cent[1200 - k] = to_q24(g, 49);
    end
  endtask

  function automatic ratio_res_t pitch_ratio(logic [15:0] raw);
    logic         neg;
    logic [16:0]  mag;
    int           oct, rem, si, ci, e;
    logic [127:0] prod;
    logic [63:0]  p, v;
    ratio_res_t   r;
    neg = raw[15];
    mag = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    oct = int'(mag) / 1200;
    rem = int'(mag) % 1200;
    si = rem / 100;
    ci = rem % 100;
    if (neg) prod = {64'd0, dn_semi[si]} * {64'd0, dn_cent[ci]};
    else prod = {64'd0, up_semi[si]} * {64'd0, up_cent[ci]};
    p = prod[TBITS +: 64];
    e = (neg ? -oct : oct) + FRAC - TBITS;
    v = '0;
    r.sat = 1'b0;
    if (e >= 0) begin
      if (e > 30 && p != 0) begin
        r.sat = 1'b1;
      end else begin
        v = p << e;
        if (v > RATIO_MAX) r.sat = 1'b1;
      end
    end else if (-e < 64) begin
      v = p >> (-e);
    end
    r.ratio = r.sat ? '1 : v[30:0];
    return r;
  endfunction

  // source side
  always @(posedge clk) begin : drive
    logic        acc, nv;
    logic [15:0] nd;
    cents_item_t nx;
    int unsigned sent_now;
    acc = in_tvalid && in_tready;
    nv = 1'b0;
    nd = in_tdata;
    sent_now = n_sent + (acc ? 1 : 0);
    if (cyc[6:0] == 7'd0) tx_pct = $urandom_range(0, 3) * 10;
    quiet <= (cents_pend.size() < QUIET_TAIL);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (acc) begin
        ratio_due.push_back(pitch_ratio(in_tdata));
        if (in_tdata[15]) n_neg++;
        n_sent <= sent_now;
      end
      if (in_tvalid && !in_tready) begin
        nv = 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (cents_pend.size() > 0) begin
        if (cents_pend[0].drain && sent_now != n_recv) begin
          // hold off until the pipeline has emptied
        end else if (!quiet && $urandom_range(0, 99) < tx_pct) begin
          tx_gap = $urandom_range(1, 16) - 1;
        end else begin
          nx = cents_pend.pop_front();
          nv = 1'b1;
          nd = nx.cents;
        end
      end
      in_tvalid <= nv;
      in_tdata <= nd;
    end
  end

  // sink side and checking
  always @(posedge clk) begin : watch
    logic       rdy;
    ratio_res_t exp_r;
    if (cyc[6:0] == 7'd64) rx_pct = $urandom_range(0, 3) * 10;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_recv <= n_recv + 1;
        if (ratio_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual tdata=%h tuser=%b",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          exp_r = ratio_due.pop_front();
          if (exp_r.sat) n_sat++;
          if (exp_r.ratio == '0) n_zero++;
          if (out_tdata[30:0] !== exp_r.ratio) begin
            $display("%0t: ratio_q12 mismatch, expected %0d actual %0d",
                     $time, exp_r.ratio, out_tdata[30:0]);
            errors++;
          end
          if (out_tdata[31] !== 1'b0) begin
            $display("%0t: tdata pad bit mismatch, expected 0 actual %b", $time, out_tdata[31]);
            errors++;
          end
          if (out_tuser !== exp_r.sat) begin
            $display("%0t: saturated mismatch, expected %b actual %b",
                     $time, exp_r.sat, out_tuser);
            errors++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_pct) begin
        rx_stall = $urandom_range(1, 16) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic add_cents(int c, bit drain = 1'b0);
    cents_item_t it;
    it.cents = 16'(c);
    it.drain = drain;
    cents_pend.push_back(it);
  endtask

  initial begin : stim
    int c, pick;
    make_ratio_tables();

    // extremes, octave and semitone edges, saturation edge, tiny ratios
    add_cents(0);
    add_cents(1);
    add_cents(-1);
    add_cents(99);
    add_cents(-99);
    add_cents(100);
    add_cents(1199);
    add_cents(-1199);
    add_cents(1200);
    add_cents(-1200);
    add_cents(-2400, 1'b1);
    add_cents(-12000);
    add_cents(-28800);
    add_cents(14400);
    add_cents(22700);
    add_cents(22799);
    add_cents(22800);
    add_cents(22801);
    add_cents(32767);
    add_cents(-32767);
    add_cents(-32768);
    add_cents(-32400);
    add_cents(21599);
    add_cents(-600);

    for (int i = 0; i < 450; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) c = $urandom_range(0, 65535);
      else if (pick < 60) c = int'($urandom_range(0, 4800)) - 2400;
      else if (pick < 75) c = 22800 + int'($urandom_range(0, 400)) - 200;
      else if (pick < 90) c = -int'($urandom_range(12000, 32768));
      else c = (int'($urandom_range(0, 54)) - 27) * 1200 + int'($urandom_range(0, 4)) - 2;
      add_cents(c, (i == 150 || i == 350));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cents_pend.size() != 0 || in_tvalid || n_sent != n_recv) @(posedge clk);
    repeat (24) @(posedge clk);

    if (ratio_due.size() != 0) begin
      $display("%0t: %0d results still outstanding at end", $time, ratio_due.size());
      errors++;
    end
    $display("covered %0d conversions (%0d negative offsets), %0d saturated, %0d truncated to zero",
             n_recv, n_neg, n_sat, n_zero);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/c2pr_pkg.sv
design/c2pr_pipe.sv
design/cents_to_pitch_ratio.sv
tb/sv/tb.sv
